### sv/stunbrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stunbrp_pkg;

  localparam logic [15:0] MAX_DATAGRAM_BYTES = 16'd65535;

  localparam logic [31:0] COOKIE        = 32'h2112A442;
  localparam logic [15:0] TYPE_SUCCESS  = 16'h0101;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [15:0] ATTR_MAPPED   = 16'h0001;
  localparam logic [7:0]  FAMILY_V4     = 8'h01;
  localparam logic [16:0] END_SAT       = 17'h1FFFF;
  localparam logic [16:0] FIRST_ATTR    = 17'd20;
  localparam logic [15:0] HEADER_BYTES  = 16'd20;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER   = 3'd1;
  localparam logic [2:0] ST_TID_MISMATCH = 3'd2;
  localparam logic [2:0] ST_LEN_OVERRUN  = 3'd3;
  localparam logic [2:0] ST_ATTR_OVERRUN = 3'd4;
  localparam logic [2:0] ST_NONE         = 3'd5;
  localparam logic [2:0] ST_TOO_LONG     = 3'd6;

  // register select is paddr[3]: byte address 0 or 8
  localparam logic REG_TID_HIGH = 1'b0;
  localparam logic REG_TID_LOW  = 1'b1;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] address;
    logic [2:0]  status;
  } result_t;

endpackage

`default_nettype wire

### sv/stun_binding_response_parser_top.sv
// A result is loaded into the result register when the last byte leaves the input register.
// Throughput: one byte per cycle; the input register and the result register decouple
// the two sides, so a waiting result stalls input only when a further last byte arrives.
// Reset clears both transaction id registers and all per-datagram parse state.
// Per-datagram state returns to its reset value after every verdict.
`timescale 1ns / 1ps
`default_nettype none

module stun_binding_response_parser_top
  import stunbrp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // byte stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  // verdict out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // [2:0] status, [34:3] mapped_address,
                                      // [50:35] external port, [55:51] zero
);

  logic [31:0] tid_high;
  logic [63:0] tid_low;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        proc;

  logic        out_valid;
  result_t     out_data;
  result_t     result_next;

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] declared_length, declared_length_next;
  logic        header_good, header_good_next;
  logic        transaction_good, transaction_good_next;
  logic [16:0] next_attribute_start, next_attribute_start_next;
  logic [15:0] attribute_type_word, attribute_type_word_next;
  logic [15:0] attribute_length_word, attribute_length_word_next;
  logic [7:0]  family_byte, family_byte_next;
  logic [15:0] port_capture, port_capture_next;
  logic [31:0] address_capture, address_capture_next;
  logic        match_found, match_found_next;
  logic [16:0] required_end, required_end_next;
  logic [15:0] attr_start, attr_start_next;
  logic        in_attr, in_attr_next;
  logic        too_long, too_long_next;

  // ---------------- configuration
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_TID_LOW) ? tid_low : {32'd0, tid_high};

  always_ff @(posedge clk) begin
    if (rst) begin
      tid_high <= '0;
      tid_low  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == REG_TID_LOW) begin
        tid_low <= pwdata;
      end else begin
        tid_high <= pwdata[31:0];
      end
    end
  end

  // ---------------- input register
  // only a last byte needs the result register free
  assign proc     = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // ---------------- parse step
  always_comb begin
    logic [4:0]  hi;
    logic [7:0]  expect_byte;
    logic [15:0] a_start;
    logic        a_in;
    logic [15:0] rel;
    logic [15:0] len_new;
    logic [16:0] padded;
    logic [17:0] end_full;
    logic [31:0] addr;
    logic [15:0] port;

    byte_position_next         = byte_position;
    declared_length_next       = declared_length;
    header_good_next           = header_good;
    transaction_good_next      = transaction_good;
    next_attribute_start_next  = next_attribute_start;
    attribute_type_word_next   = attribute_type_word;
    attribute_length_word_next = attribute_length_word;
    family_byte_next           = family_byte;
    port_capture_next          = port_capture;
    address_capture_next       = address_capture;
    match_found_next           = match_found;
    required_end_next          = required_end;
    attr_start_next            = attr_start;
    in_attr_next               = in_attr;
    too_long_next              = too_long;

    hi          = byte_position[4:0];
    expect_byte = '0;
    a_start     = attr_start;
    a_in        = in_attr;
    rel         = '0;
    len_new     = {attribute_length_word[7:0], in_byte};
    padded      = '0;
    end_full    = '0;
    addr        = '0;
    port        = '0;

    if (byte_position >= MAX_DATAGRAM_BYTES) begin
      too_long_next = 1'b1;
    end else if (!too_long) begin
      byte_position_next = byte_position + 16'd1;
      if (byte_position < HEADER_BYTES) begin
        priority if (hi < 5'd2) begin
          expect_byte = TYPE_SUCCESS[8*(5'd1 - hi) +: 8];
          if (in_byte != expect_byte) header_good_next = 1'b0;
        end else if (hi < 5'd4) begin
          declared_length_next = {declared_length[7:0], in_byte};
        end else if (hi < 5'd8) begin
          expect_byte = COOKIE[8*(5'd7 - hi) +: 8];
          if (in_byte != expect_byte) header_good_next = 1'b0;
        end else if (hi < 5'd12) begin
          expect_byte = tid_high[8*(5'd11 - hi) +: 8];
          if (in_byte != expect_byte) transaction_good_next = 1'b0;
        end else begin
          expect_byte = tid_low[8*(5'd19 - hi) +: 8];
          if (in_byte != expect_byte) transaction_good_next = 1'b0;
        end
      end else begin
        // an attribute header starts here if it fits in the declared message
        if (!match_found && ({1'b0, byte_position} == next_attribute_start) &&
            (({1'b0, next_attribute_start} + 18'd4) <=
             (18'd20 + {2'b00, declared_length}))) begin
          a_start = byte_position;
          a_in    = 1'b1;
        end
        attr_start_next = a_start;
        in_attr_next    = a_in;
        if (a_in) begin
          rel = byte_position - a_start;
          priority if (rel < 16'd2) begin
            attribute_type_word_next = {attribute_type_word[7:0], in_byte};
          end else if (rel < 16'd4) begin
            attribute_length_word_next = len_new;
            if (rel == 16'd3) begin
              padded   = ({1'b0, len_new} + 17'd3) & ~17'd3;
              end_full = {2'b00, a_start} + 18'd4 + {1'b0, padded};
              required_end_next = (end_full > {1'b0, END_SAT}) ? END_SAT : end_full[16:0];
              next_attribute_start_next = required_end_next;
              if (!((attribute_type_word == ATTR_XOR_MAPPED ||
                     attribute_type_word == ATTR_MAPPED) && len_new >= 16'd8)) begin
                in_attr_next = 1'b0;
              end
            end
          end else if (rel == 16'd5) begin
            family_byte_next = in_byte;
            if (in_byte == FAMILY_V4) match_found_next = 1'b1;
            else in_attr_next = 1'b0;
          end else if (rel == 16'd6 || rel == 16'd7) begin
            port_capture_next = {port_capture[7:0], in_byte};
          end else if (rel >= 16'd8 && rel < 16'd12) begin
            address_capture_next = {address_capture[23:0], in_byte};
            if (rel == 16'd11) in_attr_next = 1'b0;
          end else begin
            // reserved byte of the attribute or trailing value bytes
            in_attr_next = a_in;
          end
        end
      end
    end

    // verdict on the state as it stands after this byte
    result_next.status = ST_NONE;
    priority if (too_long_next) begin
      result_next.status = ST_TOO_LONG;
    end else if (byte_position_next < HEADER_BYTES || !header_good_next) begin
      result_next.status = ST_BAD_HEADER;
    end else if (!transaction_good_next) begin
      result_next.status = ST_TID_MISMATCH;
    end else if (({1'b0, declared_length_next} + 17'd20) > {1'b0, byte_position_next}) begin
      result_next.status = ST_LEN_OVERRUN;
    end else if (required_end_next > {1'b0, byte_position_next}) begin
      result_next.status = ST_ATTR_OVERRUN;
    end else if (match_found_next) begin
      result_next.status = ST_OK;
      addr = address_capture_next;
      port = port_capture_next;
      if (attribute_type_word_next == ATTR_XOR_MAPPED) begin
        addr = addr ^ COOKIE;
        port = port ^ COOKIE[31:16];
      end
    end else begin
      result_next.status = ST_NONE;
    end
    result_next.address = addr;
    result_next.port    = port;
  end

  always_ff @(posedge clk) begin
    if (rst || (proc && in_last)) begin
      byte_position         <= '0;
      declared_length       <= '0;
      header_good           <= 1'b1;
      transaction_good      <= 1'b1;
      next_attribute_start  <= FIRST_ATTR;
      attribute_type_word   <= '0;
      attribute_length_word <= '0;
      family_byte           <= '0;
      port_capture          <= '0;
      address_capture       <= '0;
      match_found           <= 1'b0;
      required_end          <= '0;
      attr_start            <= '0;
      in_attr               <= 1'b0;
      too_long              <= 1'b0;
    end else if (proc) begin
      byte_position         <= byte_position_next;
      declared_length       <= declared_length_next;
      header_good           <= header_good_next;
      transaction_good      <= transaction_good_next;
      next_attribute_start  <= next_attribute_start_next;
      attribute_type_word   <= attribute_type_word_next;
      attribute_length_word <= attribute_length_word_next;
      family_byte           <= family_byte_next;
      port_capture          <= port_capture_next;
      address_capture       <= address_capture_next;
      match_found           <= match_found_next;
      required_end          <= required_end_next;
      attr_start            <= attr_start_next;
      in_attr               <= in_attr_next;
      too_long              <= too_long_next;
    end
  end

  // ---------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last) begin
      out_data <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data};

  // ---------------- checks
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> (out_data.address == '0 && out_data.port == '0))
    else $error("non-ok verdict carries an address or port");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status <= ST_TOO_LONG))
    else $error("verdict code out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (proc && in_last) |=> (byte_position == '0 && !match_found && !too_long && !in_attr))
    else $error("datagram state not cleared after verdict");

  a_match_family: assert property (@(posedge clk) disable iff (rst)
    match_found |-> (family_byte == FAMILY_V4))
    else $error("match recorded without IPv4 family");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_last && out_valid && !m_tready))
    else $error("input stalled without a pending verdict");

endmodule

`default_nettype wire
